[rtl/fse_pkg.sv]
package fse_pkg;

  // Default line store depth in pixels
  localparam int LINE_PIXELS_DEF = 1024;

  // Field and register widths
  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int PIXEL_W  = 8;
  localparam int SCALE_W  = 2;
  localparam int SRCW_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // Reset values of the configuration registers
  localparam logic [SCALE_W-1:0] SCALE_RST = 2'd1;
  localparam logic [SRCW_W-1:0]  SRCW_RST  = 11'd640;

  // Scale code that enables pixel and line doubling
  localparam logic [SCALE_W-1:0] SCALE_DOUBLE = 2'd2;

  // Mask applied to each nibble in 3-bit colour mode
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'b0000_0111;

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BYTE      = 2'd0,
    FUNC_REPLAY    = 2'd1,
    FUNC_GUI_READY = 2'd2,
    FUNC_FRAME_END = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE        = 2'd0,
    REG_COLOR_3BIT   = 2'd1,
    REG_SOURCE_WIDTH = 2'd2
  } cfg_reg_t;

endpackage

[rtl/framebuffer_scanout_expander.sv]
// An accepted item is held in the expand stage; each of its results then
// passes through the result register to the outputs.
// Throughput: one result per cycle while the output does not stall; an item
// makes 1, 2 or 4 results and the next item is taken as its last result advances; a replay at scale one makes none.
// Reset: synchronous; clears positions, flip state and configuration.
// The line store is not cleared and holds undefined data until written.
module framebuffer_scanout_expander
  import fse_pkg::*;
#(
  parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [BYTE_W-1:0]     source_byte,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_W-1:0]    pixel,
  output logic                  last,
  output logic                  line_done,
  output logic                  front_buffer,
  output logic                  swapped
);

  localparam int AW  = $clog2(LINE_PIXELS);
  localparam int PW  = AW + 1;
  localparam int SWW = (PW > SRCW_W + 1) ? PW : SRCW_W + 1;

  // Configuration registers
  logic [SCALE_W-1:0] scale;
  logic               color_3bit;
  logic [SRCW_W-1:0]  source_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= SCALE_RST;
      color_3bit   <= 1'b0;
      source_width <= SRCW_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE:        scale        <= cfg_data[SCALE_W-1:0];
        REG_COLOR_3BIT:   color_3bit   <= cfg_data[0];
        REG_SOURCE_WIDTH: source_width <= cfg_data[SRCW_W-1:0];
        default: ;
      endcase
    end
  end

  // Screen width: source width, doubled at scale two, saturated at the line store depth, zero acts as one
  logic           dbl;
  logic [SWW-1:0] scaled_w;
  logic [SWW-1:0] sat_w;
  logic [PW-1:0]  screen_w;

  always_comb begin
    dbl      = (scale == SCALE_DOUBLE);
    scaled_w = dbl ? SWW'({source_width, 1'b0}) : SWW'(source_width);
    if (scaled_w > SWW'(LINE_PIXELS)) begin
      sat_w = SWW'(LINE_PIXELS);
    end else if (scaled_w == '0) begin
      sat_w = SWW'(1);
    end else begin
      sat_w = scaled_w;
    end
    screen_w = sat_w[PW-1:0];
  end

  // Expand stage registers
  logic              p_valid;
  logic [FUNC_W-1:0] p_func;
  logic [BYTE_W-1:0] p_byte;
  logic [1:0]        p_cnt;
  logic [1:0]        p_nlast;

  // Result register
  logic               r_valid;
  logic [PIXEL_W-1:0] r_pixel;
  logic               r_from_ram;
  logic               r_last;
  logic               r_line_done;
  logic               r_front;
  logic               r_swapped;

  // Line and flip state
  logic [AW-1:0] write_pos, write_pos_next;
  logic [AW-1:0] replay_pos, replay_pos_next;
  logic          scan_buffer, scan_buffer_next;
  logic          draw_ready, draw_ready_next;

  // Stage control
  logic       p_adv;
  logic       p_last;
  logic       in_xfer;
  logic [1:0] in_nlast;
  logic       in_keep;

  assign p_adv    = p_valid && (!r_valid || !out_stall);
  assign p_last   = (p_cnt == p_nlast);
  assign in_stall = p_valid && !(p_last && p_adv);
  assign in_xfer  = in_valid && !in_stall;

  // Count of results for the incoming item, less one; drop a replay at scale one
  always_comb begin
    in_nlast = 2'd0;
    in_keep  = 1'b1;
    case (func_t'(func))
      FUNC_BYTE:   in_nlast = {color_3bit & dbl, color_3bit | dbl};
      FUNC_REPLAY: in_keep  = dbl;
      default:     in_nlast = 2'd0;
    endcase
  end

  // Hold or advance the expand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_xfer) begin
      p_valid <= in_keep;
    end else if (p_adv && p_last) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_func  <= func;
      p_byte  <= source_byte;
      p_nlast <= in_nlast;
      p_cnt   <= 2'd0;
    end else if (p_adv && !p_last) begin
      p_cnt <= p_cnt + 2'd1;
    end
  end

  // Pixel chosen from the byte for the current result
  logic               pix_hi;
  logic [PIXEL_W-1:0] src_pix;

  always_comb begin
    pix_hi = dbl ? p_cnt[1] : p_cnt[0];
    if (color_3bit) begin
      src_pix = pix_hi ? ((p_byte >> 4) & NIBBLE_MASK) : (p_byte & NIBBLE_MASK);
    end else begin
      src_pix = p_byte;
    end
  end

  // Position advance with wrap at screen width
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] rp_inc;
  logic          wp_wrap;
  logic          rp_wrap;

  assign wp_inc  = {1'b0, write_pos} + PW'(1);
  assign rp_inc  = {1'b0, replay_pos} + PW'(1);
  assign wp_wrap = (wp_inc >= screen_w);
  assign rp_wrap = (rp_inc >= screen_w);

  // Result and state update for one expand step
  logic               ram_we;
  logic               ram_re;
  logic [PIXEL_W-1:0] res_pixel;
  logic               res_from_ram;
  logic               res_done;
  logic               res_swapped;

  always_comb begin
    write_pos_next   = write_pos;
    replay_pos_next  = replay_pos;
    scan_buffer_next = scan_buffer;
    draw_ready_next  = draw_ready;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    res_pixel        = '0;
    res_from_ram     = 1'b0;
    res_done         = 1'b0;
    res_swapped      = 1'b0;
    if (p_adv) begin
      case (func_t'(p_func))
        FUNC_BYTE: begin
          ram_we         = dbl;
          res_pixel      = src_pix;
          res_done       = wp_wrap;
          write_pos_next = wp_wrap ? '0 : wp_inc[AW-1:0];
        end
        FUNC_REPLAY: begin
          ram_re          = 1'b1;
          res_from_ram    = 1'b1;
          res_done        = rp_wrap;
          replay_pos_next = rp_wrap ? '0 : rp_inc[AW-1:0];
        end
        FUNC_GUI_READY: begin
          draw_ready_next = 1'b1;
        end
        FUNC_FRAME_END: begin
          if (draw_ready) begin
            scan_buffer_next = !scan_buffer;
            draw_ready_next  = 1'b0;
            res_swapped      = 1'b1;
          end
          write_pos_next  = '0;
          replay_pos_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos   <= '0;
      replay_pos  <= '0;
      scan_buffer <= 1'b0;
      draw_ready  <= 1'b0;
    end else begin
      write_pos   <= write_pos_next;
      replay_pos  <= replay_pos_next;
      scan_buffer <= scan_buffer_next;
      draw_ready  <= draw_ready_next;
    end
  end

  // Line store for the doubled line
  logic [PIXEL_W-1:0] ram_rdata;

  fse_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (LINE_PIXELS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos),
    .wdata (src_pix),
    .re    (ram_re),
    .raddr (replay_pos),
    .rdata (ram_rdata)
  );

  // Result register: load on advance, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (p_adv) begin
      r_valid <= 1'b1;
    end else if (!out_stall) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      r_pixel     <= res_pixel;
      r_from_ram  <= res_from_ram;
      r_last      <= p_last;
      r_line_done <= res_done;
      r_front     <= scan_buffer_next;
      r_swapped   <= res_swapped;
    end
  end

  assign out_valid    = r_valid;
  assign pixel        = r_from_ram ? ram_rdata : r_pixel;
  assign last         = r_last;
  assign line_done    = r_line_done;
  assign front_buffer = r_front;
  assign swapped      = r_swapped;

endmodule

[rtl/fse_ram.sv]
module fse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[dv/framebuffer_scanout_expander_tb.sv]
`timescale 1ns / 1ps

module framebuffer_scanout_expander_tb
  import fse_pkg::*;
();

  localparam int LINE_PX     = LINE_PIXELS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 8;
  // Two copies of the expander state: one follows accepted transfers, the
  // other runs ahead while items are queued so replays never hit unwritten store
  localparam int TRACK = 0;
  localparam int PLAN  = 1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    logic               line_done;
    logic               front_buffer;
    logic               swapped;
  } scan_res_t;

  typedef struct packed {
    func_t             f;
    logic [BYTE_W-1:0] b;
  } feed_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  cfg_reg_t              cfg_index = REG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  func_t                 func_drv = FUNC_BYTE;
  logic [BYTE_W-1:0]     byte_drv = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIXEL_W-1:0]    pixel;
  logic                  last;
  logic                  line_done;
  logic                  front_buffer;
  logic                  swapped;

  // Expander state, one copy per index
  logic [PIXEL_W-1:0] line_mem     [2][LINE_PX];
  bit                 line_written [2][LINE_PX];
  int unsigned        wr_pos [2];
  int unsigned        rp_pos [2];
  bit                 front  [2];
  bit                 drawer_ready [2];
  logic [SCALE_W-1:0] scale_r  [2];
  bit                 color3_r [2];
  logic [SRCW_W-1:0]  width_r  [2];

  feed_t     pending[$];
  scan_res_t pixels_due[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        gap_left = 0;
  int        burst_left = 0;
  int        stall_phase = 0;
  int        stall_mode = 0;

  framebuffer_scanout_expander i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func_drv),
    .source_byte (byte_drv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel       (pixel),
    .last        (last),
    .line_done   (line_done),
    .front_buffer(front_buffer),
    .swapped     (swapped)
  );

  always #1 clk = ~clk;

  function automatic int unsigned screen_px(int c);
    int unsigned w;
    w = width_r[c] * ((scale_r[c] == SCALE_DOUBLE) ? 2 : 1);
    if (w > LINE_PX) w = LINE_PX;
    if (w == 0) w = 1;
    return w;
  endfunction

  function automatic scan_res_t pack_res(logic [PIXEL_W-1:0] p, bit done, bit fb, bit swp);
    pack_res = '{p, 1'b0, done, fb, swp};
  endfunction

  // Work out the pixels one item makes and advance copy c of the state
  function automatic void expand_item(int c, func_t f, logic [BYTE_W-1:0] b);
    scan_res_t          res[$];
    logic [PIXEL_W-1:0] px[2];
    logic [PIXEL_W-1:0] p;
    int                 np;
    int                 reps;
    bit                 doubled;
    bit                 done;
    bit                 swp;
    doubled = (scale_r[c] == SCALE_DOUBLE);
    case (f)
      FUNC_BYTE: begin
        reps = doubled ? 2 : 1;
        if (color3_r[c]) begin
          px[0] = b & NIBBLE_MASK;
          px[1] = (b >> 4) & NIBBLE_MASK;
          np = 2;
        end else begin
          px[0] = b;
          px[1] = '0;
          np = 1;
        end
        for (int i = 0; i < np; i++) begin
          for (int r = 0; r < reps; r++) begin
            if (doubled && wr_pos[c] < LINE_PX) begin
              line_mem[c][wr_pos[c]] = px[i];
              line_written[c][wr_pos[c]] = 1'b1;
            end
            wr_pos[c]++;
            done = (wr_pos[c] >= screen_px(c));
            if (done) wr_pos[c] = 0;
            res.push_back(pack_res(px[i], done, front[c], 1'b0));
          end
        end
      end
      FUNC_REPLAY: begin
        // no line doubling at scale one, so nothing comes out
        if (doubled) begin
          p = (rp_pos[c] < LINE_PX) ? line_mem[c][rp_pos[c]] : '0;
          rp_pos[c]++;
          done = (rp_pos[c] >= screen_px(c));
          if (done) rp_pos[c] = 0;
          res.push_back(pack_res(p, done, front[c], 1'b0));
        end
      end
      FUNC_GUI_READY: begin
        drawer_ready[c] = 1'b1;
        res.push_back(pack_res('0, 1'b0, front[c], 1'b0));
      end
      default: begin
        swp = drawer_ready[c];
        if (swp) begin
          front[c] = ~front[c];
          drawer_ready[c] = 1'b0;
        end
        wr_pos[c] = 0;
        rp_pos[c] = 0;
        res.push_back(pack_res('0, 1'b0, front[c], swp));
      end
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    if (c == TRACK) foreach (res[i]) pixels_due.push_back(res[i]);
  endfunction

  // Queue one item; a replay that would read an unwritten entry becomes a byte
  task automatic queue_item(func_t f, logic [BYTE_W-1:0] b);
    feed_t it;
    if (f == FUNC_REPLAY && scale_r[PLAN] == SCALE_DOUBLE &&
        !line_written[PLAN][rp_pos[PLAN]])
      f = FUNC_BYTE;
    it.f = f;
    it.b = b;
    pending.push_back(it);
    expand_item(PLAN, f, b);
  endtask

  task automatic fill_random(int n, int byte_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < byte_pct) begin
        queue_item(FUNC_BYTE, 8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      queue_item(FUNC_REPLAY, 8'($urandom));
        else if (r < 85) queue_item(FUNC_GUI_READY, 8'($urandom));
        else             queue_item(FUNC_FRAME_END, 8'($urandom));
      end
    end
  endtask

  // Write a register while the expander is idle; both state copies follow
  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    for (int c = 0; c < 2; c++) begin
      case (idx)
        REG_SCALE:        scale_r[c]  = val[SCALE_W-1:0];
        REG_COLOR_3BIT:   color3_r[c] = val[0];
        REG_SOURCE_WIDTH: width_r[c]  = val[SRCW_W-1:0];
        default: ;
      endcase
    end
  endtask

  // Hold until every queued item is taken and every pixel has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || pixels_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender: bursts of transfers with random gaps in between
  always @(posedge clk) begin : feed_drive
    feed_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expand_item(TRACK, func_drv, byte_drv);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          func_drv <= nxt.f;
          byte_drv <= nxt.b;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 :
                          $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, then pick the next stall
  always @(posedge clk) begin : pixel_check
    scan_res_t got;
    scan_res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{pixel, last, line_done, front_buffer, swapped};
      if (pixels_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no pixel, got pixel %02h last %0b line_done %0b front %0b swapped %0b",
                 $time, got.pixel, got.last, got.line_done, got.front_buffer, got.swapped);
      end else begin
        want = pixels_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: expected pixel %02h last %0b line_done %0b front %0b swapped %0b, got pixel %02h last %0b line_done %0b front %0b swapped %0b",
                   $time, want.pixel, want.last, want.line_done, want.front_buffer,
                   want.swapped, got.pixel, got.last, got.line_done,
                   got.front_buffer, got.swapped);
        end
      end
    end
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase % 3 != 0);
    endcase
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("framebuffer_scanout_expander_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int scale_tab [7];
    int color_tab [7];
    int count_tab [7];
    int width;
    scale_tab = '{2, 2, 1, 1, 2, 1, 2};
    color_tab = '{1, 0, 1, 0, 1, 0, 0};
    count_tab = '{20, 15, 12, 12, 0, 10, 15};
    for (int c = 0; c < 2; c++) begin
      wr_pos[c]       = 0;
      rp_pos[c]       = 0;
      front[c]        = 1'b0;
      drawer_ready[c] = 1'b0;
      scale_r[c]      = SCALE_RST;
      color3_r[c]     = 1'b0;
      width_r[c]      = SRCW_RST;
      for (int i = 0; i < LINE_PX; i++) line_written[c][i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: flip handshake, replay at scale one, byte extremes
    queue_item(FUNC_GUI_READY, 8'h00);
    queue_item(FUNC_GUI_READY, 8'hFF);
    queue_item(FUNC_FRAME_END, 8'h00);
    queue_item(FUNC_FRAME_END, 8'hFF);
    queue_item(FUNC_REPLAY, 8'h00);
    queue_item(FUNC_BYTE, 8'h00);
    queue_item(FUNC_BYTE, 8'hFF);
    queue_item(FUNC_BYTE, 8'h80);
    queue_item(FUNC_BYTE, 8'h01);
    wait_idle();

    // Narrowest doubled line in 3-bit mode; the line left half done ends at once
    set_reg(REG_SCALE, CFG_DATA_W'(SCALE_DOUBLE));
    set_reg(REG_COLOR_3BIT, CFG_DATA_W'(1));
    set_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(1));
    queue_item(FUNC_BYTE, 8'hFF);
    queue_item(FUNC_BYTE, 8'h00);
    queue_item(FUNC_BYTE, 8'h5A);
    queue_item(FUNC_BYTE, 8'h88);
    for (int i = 0; i < 4; i++) queue_item(FUNC_REPLAY, 8'h00);
    queue_item(FUNC_GUI_READY, 8'h00);
    queue_item(FUNC_FRAME_END, 8'h00);
    queue_item(FUNC_REPLAY, 8'h00);
    wait_idle();

    // Random phases over a spread of settings
    for (int p = 0; p < 7; p++) begin
      if (p == 4)      width = 40;
      else if (p == 5) width = 1024;
      else if (p == 3) width = 1;
      else             width = $urandom_range(2, 9);
      set_reg(REG_SCALE, CFG_DATA_W'(scale_tab[p]));
      set_reg(REG_COLOR_3BIT, CFG_DATA_W'(color_tab[p]));
      set_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(width));
      if (p == 0) begin
        fill_random(count_tab[p] / 2, 60);
        wait_idle();
        fill_random(count_tab[p] - count_tab[p] / 2, 60);
      end else if (p == 4) begin
        // one full doubled line in 3-bit mode, then replay part of it
        queue_item(FUNC_FRAME_END, 8'($urandom));
        for (int i = 0; i < 20; i++) queue_item(FUNC_BYTE, 8'($urandom));
        fill_random(15, 20);
      end else begin
        fill_random(count_tab[p], 60);
      end
      wait_idle();
    end

    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("framebuffer_scanout_expander_tb: done, clean");
    end else begin
      $display("framebuffer_scanout_expander_tb: done, errors");
    end
    $finish;
  end

endmodule
